/* hw/rtl/psac_pkg.sv */
package psac_pkg;

  // input word, one per 2.5 ms tick
  typedef struct packed {
    logic        sw_view_pressed;
    logic        sw_up_pressed;
    logic        sw_down_pressed;
    logic [11:0] reading_mv;
    logic [1:0]  mode;
  } in_t;

  // result word, one per tick
  typedef struct packed {
    logic        alarm_on;
    logic [15:0] display_word;
    logic [11:0] setpoint_mv;
    logic        compare_enabled;
    logic        settings_view;
  } out_t;

  // configuration register file
  typedef struct packed {
    logic [7:0]  short_press_ticks;
    logic [7:0]  long_press_ticks;
    logic [11:0] setpoint_max;
    logic [9:0]  fine_step;
    logic [9:0]  coarse_step;
    logic [7:0]  repeat_ticks;
    logic [9:0]  blink_ticks;
  } cfg_t;

  // button timer events
  typedef enum logic [1:0] {
    EvNone,
    EvLongReached,
    EvShortRelease,
    EvLongRelease
  } btn_ev_e;

  // serial command codes
  localparam logic [1:0] CmdNone   = 2'd0;
  localparam logic [1:0] CmdToggle = 2'd1;
  localparam logic [1:0] CmdUp     = 2'd2;
  localparam logic [1:0] CmdDown   = 2'd3;

  // register indexes
  localparam logic [2:0] RegShortPress = 3'd0;
  localparam logic [2:0] RegLongPress  = 3'd1;
  localparam logic [2:0] RegSetpointMax = 3'd2;
  localparam logic [2:0] RegFineStep   = 3'd3;
  localparam logic [2:0] RegCoarseStep = 3'd4;
  localparam logic [2:0] RegRepeat     = 3'd5;
  localparam logic [2:0] RegBlink      = 3'd6;

  localparam int unsigned PressTimerW = 9;
  localparam int unsigned CfgDataW    = 12;

  localparam logic [11:0] SetpointReset = 12'd1600;

  localparam cfg_t CfgReset = '{
    short_press_ticks: 8'd20,
    long_press_ticks:  8'd200,
    setpoint_max:      12'd3300,
    fine_step:         10'd10,
    coarse_step:       10'd100,
    repeat_ticks:      8'd40,
    blink_ticks:       10'd400
  };

  localparam logic [4:0] DigitC     = 5'd12;
  localparam logic [4:0] DigitBlank = 5'd16;

  // seven-segment patterns, segments HGFEDCBA active low in the high byte
  function automatic logic [15:0] glyph(input logic [4:0] d);
    logic [15:0] g;
    case (d)
      5'd0:    g = 16'hC000;
      5'd1:    g = 16'hF900;
      5'd2:    g = 16'hA400;
      5'd3:    g = 16'hB000;
      5'd4:    g = 16'h9900;
      5'd5:    g = 16'h9200;
      5'd6:    g = 16'h8200;
      5'd7:    g = 16'hF800;
      5'd8:    g = 16'h8000;
      5'd9:    g = 16'h9000;
      5'd10:   g = 16'h8800;
      5'd11:   g = 16'h8300;
      5'd12:   g = 16'hC600;
      5'd13:   g = 16'hA100;
      5'd14:   g = 16'h8600;
      5'd15:   g = 16'h8E00;
      default: g = 16'hFF00;
    endcase
    return g;
  endfunction

endpackage

/* hw/rtl/psac_btn_timer.sv */
module psac_btn_timer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                held_i,
  input  logic [7:0]          short_ticks_i,
  input  logic [7:0]          long_ticks_i,
  output psac_pkg::btn_ev_e   ev_o
);

  localparam int unsigned W = psac_pkg::PressTimerW;

  logic [W-1:0] timer_q, timer_d;
  logic [W-1:0] short_w, long_w;

  assign short_w = W'(short_ticks_i);
  assign long_w  = W'(long_ticks_i);

  always_comb begin
    timer_d = timer_q;
    ev_o    = psac_pkg::EvNone;
    if (held_i) begin
      // counts to long + 1 and parks there
      if (timer_q <= long_w) begin
        if (timer_q == long_w) begin
          ev_o = psac_pkg::EvLongReached;
        end
        timer_d = timer_q + W'(1);
      end
    end else begin
      if (timer_q > long_w) begin
        ev_o = psac_pkg::EvLongRelease;
      end else if (timer_q >= short_w) begin
        ev_o = psac_pkg::EvShortRelease;
      end
      timer_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_q <= '0;
    end else if (en_i) begin
      timer_q <= timer_d;
    end
  end

endmodule

/* hw/rtl/psac_disp.sv */
module psac_disp (
  input  logic [11:0] src_i,
  input  logic [1:0]  digit_idx_i,
  input  logic        show_c_i,
  input  logic        point_hit_i,
  output logic [15:0] word_o
);

  // reciprocal multiplies, exact over 0..4095
  localparam logic [16:0] Recip10   = 17'd52429;  // 2^19 / 10
  localparam logic [15:0] Recip100  = 16'd41944;  // 2^22 / 100
  localparam logic [12:0] Recip1000 = 13'd4195;   // 2^22 / 1000

  logic [28:0] p10;
  logic [27:0] p100;
  logic [24:0] p1000;
  logic [8:0]  q10;
  logic [5:0]  q100;
  logic [2:0]  q1000;
  logic [8:0]  q100x10;
  logic [5:0]  q1000x10;
  logic [8:0]  rem0;
  logic [5:0]  rem1;
  logic [4:0]  digit;
  logic [3:0]  sel;

  assign p10   = 29'(src_i) * 29'(Recip10);
  assign p100  = 28'(src_i) * 28'(Recip100);
  assign p1000 = 25'(src_i) * 25'(Recip1000);

  assign q10   = p10[27:19];
  assign q100  = p100[27:22];
  assign q1000 = p1000[24:22];

  // times ten as shift and add
  assign q100x10  = 9'({q100, 3'b000}) + 9'({q100, 1'b0});
  assign q1000x10 = 6'({q1000, 3'b000}) + 6'({q1000, 1'b0});

  assign rem0 = q10 - q100x10;
  assign rem1 = q100 - q1000x10;

  always_comb begin
    case (digit_idx_i)
      2'd0:    digit = 5'(rem0[3:0]);
      2'd1:    digit = 5'(rem1[3:0]);
      2'd2:    digit = 5'(q1000);
      default: digit = show_c_i ? psac_pkg::DigitC : psac_pkg::DigitBlank;
    endcase
  end

  assign sel = 4'b1000 >> digit_idx_i;

  always_comb begin
    word_o = psac_pkg::glyph(digit) | 16'(sel);
    if (point_hit_i) begin
      word_o[15] = 1'b0;
    end
  end

endmodule

/* hw/rtl/panel_setpoint_alarm_controller_core.sv */
// Panel setpoint alarm controller. Each input word is one 2.5 ms tick with three button
// levels, a millivolt reading and a serial command; each tick yields exactly one result
// word with the alarm flag, one multiplexed seven-segment digit word, the setpoint and
// the compare and view flags. An accepted word sits in an input register, and the whole
// tick (command, alarm compare, digit decode, button timing, auto-repeat) is worked in
// one pass of logic into the result register, so a word can be taken every clock cycle;
// throughput is one tick per cycle, and the only thing that holds the input is a result
// that has not yet been taken downstream. Configuration writes are always ready and
// take effect at once; write only while no tick is in flight.
module panel_setpoint_alarm_controller_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // tick input
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  psac_pkg::in_t               in_data_i,
  // result output
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output psac_pkg::out_t              out_data_o,
  // configuration writes
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [2:0]                  cfg_index_i,
  input  logic [psac_pkg::CfgDataW-1:0] cfg_data_i
);

  // saturating setpoint steps
  function automatic logic [11:0] sat_up(input logic [11:0] sp, input logic [9:0] amt,
                                         input logic [11:0] mx);
    logic [12:0] v;
    v = {1'b0, sp} + 13'(amt);
    return (v > {1'b0, mx}) ? mx : v[11:0];
  endfunction

  function automatic logic [11:0] sat_down(input logic [11:0] sp, input logic [9:0] amt);
    logic [11:0] a;
    a = 12'(amt);
    return (sp >= a) ? (sp - a) : 12'd0;
  endfunction

  // handshake and pipeline registers
  logic           in_valid_q;
  psac_pkg::in_t  in_q;
  logic           out_valid_q;
  psac_pkg::out_t out_q, out_d;
  logic           fire;

  // config
  psac_pkg::cfg_t cfg_q;

  // controller state
  logic [11:0] setpoint_q, setpoint_d;
  logic        compare_q, compare_d;
  logic        view_q, view_d;
  logic [1:0]  digit_idx_q;
  logic        point_on_q, point_on_d;
  logic [9:0]  blink_q, blink_d;
  logic [1:0]  rep_en_q, rep_en_d;
  logic [7:0]  rep_cnt_q [2];
  logic [7:0]  rep_cnt_d [2];

  // intermediate tick values
  logic [11:0] sp_cmd, sp_up, sp_dn, sp_rep0;
  logic        cmp_cmd, view_cmd;
  logic        alarm;
  logic [11:0] disp_src;
  logic        point_hit;
  logic [15:0] disp_word;
  psac_pkg::btn_ev_e ev_view, ev_up, ev_dn;

  // a tick moves from the input register to the result register when the result slot
  // is empty or being drained this cycle
  assign fire        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || fire;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  // register file, writes masked to field width, unknown indexes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= psac_pkg::CfgReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        psac_pkg::RegShortPress:  cfg_q.short_press_ticks <= cfg_data_i[7:0];
        psac_pkg::RegLongPress:   cfg_q.long_press_ticks  <= cfg_data_i[7:0];
        psac_pkg::RegSetpointMax: cfg_q.setpoint_max      <= cfg_data_i[11:0];
        psac_pkg::RegFineStep:    cfg_q.fine_step         <= cfg_data_i[9:0];
        psac_pkg::RegCoarseStep:  cfg_q.coarse_step       <= cfg_data_i[9:0];
        psac_pkg::RegRepeat:      cfg_q.repeat_ticks      <= cfg_data_i[7:0];
        psac_pkg::RegBlink:       cfg_q.blink_ticks       <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // one timer per button
  psac_btn_timer u_btn_view (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (fire),
    .held_i        (in_q.sw_view_pressed),
    .short_ticks_i (cfg_q.short_press_ticks),
    .long_ticks_i  (cfg_q.long_press_ticks),
    .ev_o          (ev_view)
  );

  psac_btn_timer u_btn_up (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (fire),
    .held_i        (in_q.sw_up_pressed),
    .short_ticks_i (cfg_q.short_press_ticks),
    .long_ticks_i  (cfg_q.long_press_ticks),
    .ev_o          (ev_up)
  );

  psac_btn_timer u_btn_dn (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (fire),
    .held_i        (in_q.sw_down_pressed),
    .short_ticks_i (cfg_q.short_press_ticks),
    .long_ticks_i  (cfg_q.long_press_ticks),
    .ev_o          (ev_dn)
  );

  // digit decode, the C on digit 3 only shows in compare view
  psac_disp u_disp (
    .src_i       (disp_src),
    .digit_idx_i (digit_idx_q),
    .show_c_i    (cmp_cmd && !view_cmd),
    .point_hit_i (point_hit),
    .word_o      (disp_word)
  );

  always_comb begin
    // serial command first
    sp_cmd   = setpoint_q;
    cmp_cmd  = compare_q;
    view_cmd = view_q;
    case (in_q.mode)
      psac_pkg::CmdToggle: begin
        view_cmd = 1'b0;
        cmp_cmd  = !compare_q;
      end
      psac_pkg::CmdUp: begin
        view_cmd = 1'b1;
        sp_cmd   = sat_up(setpoint_q, cfg_q.fine_step, cfg_q.setpoint_max);
      end
      psac_pkg::CmdDown: begin
        view_cmd = 1'b1;
        sp_cmd   = sat_down(setpoint_q, cfg_q.fine_step);
      end
      default: ;
    endcase

    // alarm against the setpoint after the command
    alarm = cmp_cmd && (in_q.reading_mv > sp_cmd);

    // display: compare view shows the reading with a fixed point, settings view
    // shows the setpoint with a blinking point
    blink_d    = blink_q;
    point_on_d = point_on_q;
    if (!view_cmd) begin
      point_on_d = 1'b1;
      disp_src   = in_q.reading_mv;
    end else begin
      if (blink_q == '0) begin
        blink_d    = cfg_q.blink_ticks;
        point_on_d = !point_on_q;
      end else begin
        blink_d = blink_q - 10'd1;
      end
      disp_src = sp_cmd;
    end
    point_hit = point_on_d && (digit_idx_q == 2'd2);

    // view button: long toggles compare, short toggles view
    compare_d = cmp_cmd;
    view_d    = view_cmd;
    if (ev_view == psac_pkg::EvLongReached) begin
      compare_d = !cmp_cmd;
    end else if (ev_view == psac_pkg::EvShortRelease) begin
      view_d = !view_cmd;
    end

    // up button
    rep_en_d = rep_en_q;
    sp_up    = sp_cmd;
    if (ev_up == psac_pkg::EvLongReached && view_d) begin
      rep_en_d[0] = 1'b1;
    end else if (ev_up == psac_pkg::EvShortRelease && view_d) begin
      sp_up = sat_up(sp_cmd, cfg_q.fine_step, cfg_q.setpoint_max);
    end else if (ev_up == psac_pkg::EvLongRelease) begin
      rep_en_d[0] = 1'b0;
    end

    // down button
    sp_dn = sp_up;
    if (ev_dn == psac_pkg::EvLongReached && view_d) begin
      rep_en_d[1] = 1'b1;
    end else if (ev_dn == psac_pkg::EvShortRelease && view_d) begin
      sp_dn = sat_down(sp_up, cfg_q.fine_step);
    end else if (ev_dn == psac_pkg::EvLongRelease) begin
      rep_en_d[1] = 1'b0;
    end

    // auto-repeat, up then down
    sp_rep0 = sp_dn;
    if (rep_en_d[0]) begin
      if (rep_cnt_q[0] == '0) begin
        rep_cnt_d[0] = cfg_q.repeat_ticks;
        sp_rep0      = sat_up(sp_dn, cfg_q.coarse_step, cfg_q.setpoint_max);
      end else begin
        rep_cnt_d[0] = rep_cnt_q[0] - 8'd1;
      end
    end else begin
      rep_cnt_d[0] = '0;
    end

    setpoint_d = sp_rep0;
    if (rep_en_d[1]) begin
      if (rep_cnt_q[1] == '0) begin
        rep_cnt_d[1] = cfg_q.repeat_ticks;
        setpoint_d   = sat_down(sp_rep0, cfg_q.coarse_step);
      end else begin
        rep_cnt_d[1] = rep_cnt_q[1] - 8'd1;
      end
    end else begin
      rep_cnt_d[1] = '0;
    end

    out_d.alarm_on        = alarm;
    out_d.display_word    = disp_word;
    out_d.setpoint_mv     = setpoint_d;
    out_d.compare_enabled = compare_d;
    out_d.settings_view   = view_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q   <= psac_pkg::SetpointReset;
      compare_q    <= 1'b0;
      view_q       <= 1'b0;
      digit_idx_q  <= '0;
      point_on_q   <= 1'b0;
      blink_q      <= '0;
      rep_en_q     <= '0;
      rep_cnt_q[0] <= '0;
      rep_cnt_q[1] <= '0;
    end else if (fire) begin
      setpoint_q   <= setpoint_d;
      compare_q    <= compare_d;
      view_q       <= view_d;
      digit_idx_q  <= digit_idx_q + 2'd1;
      point_on_q   <= point_on_d;
      blink_q      <= blink_d;
      rep_en_q     <= rep_en_d;
      rep_cnt_q[0] <= rep_cnt_d[0];
      rep_cnt_q[1] <= rep_cnt_d[1];
    end
  end

endmodule
